// ===== hw/rtl/slpa_pkg.sv =====
// ----------------------------------------------------------------------------
// slpa_pkg
// Shared types and constants for the status LED pattern arbiter.
// ----------------------------------------------------------------------------
package slpa_pkg;

  localparam int unsigned TimeBits  = 32;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned DivW      = HalfW + 1;
  localparam int unsigned TotalW    = CountW + HalfW + 1;
  localparam int unsigned StepW     = $clog2(TimeBits);

  localparam logic [HalfW-1:0]  TxPulseRst    = HalfW'(50);
  localparam logic [HalfW-1:0]  ConfirmHalfRst = HalfW'(100);
  localparam logic [CountW-1:0] ConfirmCntRst = CountW'(3);
  localparam logic [HalfW-1:0]  PairingHalfRst = HalfW'(250);

  typedef enum logic [2:0] {
    OpTick       = 3'd0,
    OpSetRadio   = 3'd1,
    OpTxPulse    = 3'd2,
    OpTrainerOn  = 3'd3,
    OpTrainerOff = 3'd4
  } slpa_op_e;

  typedef enum logic [1:0] {
    RadioOff       = 2'd0,
    RadioConnected = 2'd1,
    RadioPairing   = 2'd2
  } slpa_radio_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegBleEnable   = 3'd0,
    RegTxPulse     = 3'd1,
    RegConfirmHalf = 3'd2,
    RegConfirmCnt  = 3'd3,
    RegPairingHalf = 3'd4
  } slpa_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StMod,
    StPhase,
    StEmit
  } slpa_state_e;

endpackage

// ===== hw/rtl/slpa_if.sv =====
// ----------------------------------------------------------------------------
// slpa_if
// Valid/ready channels for items into and results out of the arbiter.
// ----------------------------------------------------------------------------
interface slpa_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        operation;
  logic [slpa_pkg::TimeBits-1:0]     now_ms;
  logic [1:0]                        new_radio_state;

  modport source (output valid, output operation, output now_ms,
                  output new_radio_state, input ready);
  modport sink   (input valid, input operation, input now_ms,
                  input new_radio_state, output ready);
endinterface

interface slpa_out_if;
  logic valid;
  logic ready;
  logic led_on;

  modport source (output valid, output led_on, input ready);
  modport sink   (input valid, input led_on, output ready);
endinterface

// ===== hw/rtl/status_led_pattern_arbiter_unit.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_arbiter_unit
// Priority arbiter driving one status LED from timestamped items.
// ----------------------------------------------------------------------------
// One item is handled at a time and gives one result: the LED level after it.
// Items other than a tick, and ticks decided by the trainer, transmit pulse,
// display enable, a dark radio state or a zero pairing half-period, go from
// execute straight to emit. A tick that must find a blink phase runs a shared
// restoring remainder unit, one bit per cycle over the 32-bit elapsed time,
// then a phase state, before emit. A new item is taken the cycle after the
// result is loaded, even while that result waits at the output.
module status_led_pattern_arbiter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slpa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [slpa_pkg::CfgDataW-1:0]   cfg_wdata_i,
  slpa_in_if.sink                         in_i,
  slpa_out_if.source                      out_o
);

  localparam int unsigned TB = slpa_pkg::TimeBits;
  localparam int unsigned HW = slpa_pkg::HalfW;
  localparam int unsigned DW = slpa_pkg::DivW;

  // configuration
  logic                        en_q;
  logic [HW-1:0]               tx_ms_q, cf_half_q, pr_half_q;
  logic [slpa_pkg::CountW-1:0] cf_cnt_q;

  // arbiter state
  slpa_pkg::slpa_state_e state_q, state_d;
  logic [1:0]    mode_q, mode_d;
  logic [TB-1:0] pat_start_q, pat_start_d;
  logic          cf_act_q, cf_act_d;
  logic [TB-1:0] cf_start_q, cf_start_d;
  logic          tx_act_q, tx_act_d;
  logic [TB-1:0] tx_start_q, tx_start_d;
  logic          trn_q, trn_d;
  logic          led_q, led_d;

  // latched item
  logic [2:0]    op_q, op_d;
  logic [TB-1:0] now_q, now_d;
  logic [1:0]    ns_q, ns_d;

  // remainder unit
  logic [TB-1:0]                  dvd_q, dvd_d;
  logic [DW-1:0]                  rem_q, rem_d, div_q, div_d;
  logic [HW-1:0]                  half_q, half_d;
  logic [slpa_pkg::StepW-1:0]     cnt_q, cnt_d;

  logic out_valid_q, out_valid_d, out_led_q, out_led_d;

  logic [TB-1:0]                  tx_el, cf_el, pat_el;
  logic [slpa_pkg::TotalW-1:0]    cf_total;
  logic [DW:0]                    trial, diff;

  assign tx_el    = now_q - tx_start_q;
  assign cf_el    = now_q - cf_start_q;
  assign pat_el   = now_q - pat_start_q;
  assign cf_total = {slpa_pkg::TotalW'(cf_cnt_q) * slpa_pkg::TotalW'(cf_half_q)}
                    << 1;
  assign trial    = {rem_q, dvd_q[TB-1]};
  assign diff     = trial - {1'b0, div_q};

  assign in_i.ready   = (state_q == slpa_pkg::StIdle);
  assign out_o.valid  = out_valid_q;
  assign out_o.led_on = out_led_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b0;
      tx_ms_q   <= slpa_pkg::TxPulseRst;
      cf_half_q <= slpa_pkg::ConfirmHalfRst;
      cf_cnt_q  <= slpa_pkg::ConfirmCntRst;
      pr_half_q <= slpa_pkg::PairingHalfRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slpa_pkg::RegBleEnable:   en_q      <= cfg_wdata_i[0];
        slpa_pkg::RegTxPulse:     tx_ms_q   <= cfg_wdata_i[HW-1:0];
        slpa_pkg::RegConfirmHalf: cf_half_q <= cfg_wdata_i[HW-1:0];
        slpa_pkg::RegConfirmCnt:  cf_cnt_q  <= cfg_wdata_i[slpa_pkg::CountW-1:0];
        slpa_pkg::RegPairingHalf: pr_half_q <= cfg_wdata_i[HW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slpa_pkg::StIdle;
      mode_q      <= slpa_pkg::RadioOff;
      pat_start_q <= '0;
      cf_act_q    <= 1'b0;
      cf_start_q  <= '0;
      tx_act_q    <= 1'b0;
      tx_start_q  <= '0;
      trn_q       <= 1'b0;
      led_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pat_start_q <= pat_start_d;
      cf_act_q    <= cf_act_d;
      cf_start_q  <= cf_start_d;
      tx_act_q    <= tx_act_d;
      tx_start_q  <= tx_start_d;
      trn_q       <= trn_d;
      led_q       <= led_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    now_q     <= now_d;
    ns_q      <= ns_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    half_q    <= half_d;
    out_led_q <= out_led_d;
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    pat_start_d = pat_start_q;
    cf_act_d    = cf_act_q;
    cf_start_d  = cf_start_q;
    tx_act_d    = tx_act_q;
    tx_start_d  = tx_start_q;
    trn_d       = trn_q;
    led_d       = led_q;
    op_d        = op_q;
    now_d       = now_q;
    ns_d        = ns_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_d       = div_q;
    half_d      = half_q;
    cnt_d       = cnt_q;
    out_led_d   = out_led_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      slpa_pkg::StIdle: begin
        if (in_i.valid) begin
          op_d    = in_i.operation;
          now_d   = in_i.now_ms;
          ns_d    = in_i.new_radio_state;
          state_d = slpa_pkg::StExec;
        end
      end

      slpa_pkg::StExec: begin
        state_d = slpa_pkg::StEmit;
        case (op_q)
          slpa_pkg::OpTick: begin
            if (!trn_q) begin
              if (tx_act_q && (tx_el < TB'(tx_ms_q))) begin
                led_d = 1'b1;
              end else begin
                tx_act_d = 1'b0;
                if (!en_q) begin
                  led_d = 1'b0;
                end else if (cf_act_q && (cf_el < TB'(cf_total))) begin
                  // blink phase of the confirmation pattern
                  dvd_d   = cf_el;
                  rem_d   = '0;
                  div_d   = {cf_half_q, 1'b0};
                  half_d  = cf_half_q;
                  cnt_d   = '0;
                  state_d = slpa_pkg::StMod;
                end else begin
                  cf_act_d = 1'b0;
                  if ((mode_q == slpa_pkg::RadioPairing) && (pr_half_q != '0)) begin
                    dvd_d   = pat_el;
                    rem_d   = '0;
                    div_d   = {pr_half_q, 1'b0};
                    half_d  = pr_half_q;
                    cnt_d   = '0;
                    state_d = slpa_pkg::StMod;
                  end else begin
                    led_d = 1'b0;
                  end
                end
              end
            end
          end
          slpa_pkg::OpSetRadio: begin
            if ((ns_q <= slpa_pkg::RadioPairing) && (ns_q != mode_q)) begin
              if (ns_q == slpa_pkg::RadioConnected) begin
                cf_act_d   = 1'b1;
                cf_start_d = now_q;
              end
              mode_d      = ns_q;
              pat_start_d = now_q;
            end
          end
          slpa_pkg::OpTxPulse: begin
            tx_act_d   = 1'b1;
            tx_start_d = now_q;
          end
          slpa_pkg::OpTrainerOn: begin
            trn_d = 1'b1;
            led_d = 1'b1;
          end
          slpa_pkg::OpTrainerOff: begin
            trn_d = 1'b0;
            led_d = 1'b0;
          end
          default: ;
        endcase
      end

      slpa_pkg::StMod: begin
        // restoring remainder, one dividend bit per cycle
        rem_d = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == slpa_pkg::StepW'(TB - 1)) begin
          state_d = slpa_pkg::StPhase;
        end
      end

      slpa_pkg::StPhase: begin
        led_d   = (rem_q < {1'b0, half_q});
        state_d = slpa_pkg::StEmit;
      end

      slpa_pkg::StEmit: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_led_d   = led_q;
          state_d     = slpa_pkg::StIdle;
        end
      end

      default: state_d = slpa_pkg::StIdle;
    endcase
  end

endmodule

// ===== hw/rtl/slpa_checker.sv =====
// ----------------------------------------------------------------------------
// slpa_checker
// Port-level checks on the status LED pattern arbiter, bound to its top level.
// ----------------------------------------------------------------------------
module slpa_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_led_i
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_led_i))
    else $error("result dropped or changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while busy");

  // no result rises right after an item is accepted
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

  // ready returns only after a result was loaded
  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i)
    else $error("ready without a result");

endmodule

bind status_led_pattern_arbiter_unit slpa_checker u_slpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_led_i   (out_o.led_on)
);

// ===== verif/status_led_pattern_arbiter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_pattern_arbiter_unit_test
// Drives timestamped items through the LED arbiter across several register
// settings, tracks the expected LED level per item and checks every result.
// ----------------------------------------------------------------------------
module status_led_pattern_arbiter_unit_test;
  import slpa_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned LongHold     = 500;
  localparam int unsigned ReportMax    = 10;
  localparam logic [2:0]  OpCodeMax    = 3'd7;
  localparam logic [1:0]  RadioBadCode = 2'd3;

  class led_scoreboard;
    bit              ble_en;
    bit [HalfW-1:0]  tx_ms;
    bit [HalfW-1:0]  confirm_half;
    bit [CountW-1:0] confirm_cnt;
    bit [HalfW-1:0]  pairing_half;
    slpa_radio_e     radio;
    bit [31:0]       pattern_t0;
    bit [31:0]       confirm_t0;
    bit [31:0]       tx_t0;
    bit              confirm_on;
    bit              tx_on;
    bit              trainer;
    bit              led;
    bit              pending_led[$];
    int unsigned     failures;

    function new();
      ble_en       = 1'b0;
      tx_ms        = TxPulseRst;
      confirm_half = ConfirmHalfRst;
      confirm_cnt  = ConfirmCntRst;
      pairing_half = PairingHalfRst;
      radio        = RadioOff;
      pattern_t0   = '0;
      confirm_t0   = '0;
      tx_t0        = '0;
      confirm_on   = 1'b0;
      tx_on        = 1'b0;
      trainer      = 1'b0;
      led          = 1'b0;
      failures     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegBleEnable:   ble_en = data[0];
        RegTxPulse:     tx_ms = data[HalfW-1:0];
        RegConfirmHalf: confirm_half = data[HalfW-1:0];
        RegConfirmCnt:  confirm_cnt = data[CountW-1:0];
        RegPairingHalf: pairing_half = data[HalfW-1:0];
        default: ;
      endcase
    endfunction

    function bit blink_lit(bit [31:0] elapsed, bit [HalfW-1:0] half);
      bit [32:0] period;
      if (half == 0) return 1'b0;
      period = {16'b0, half, 1'b0};
      return ({1'b0, elapsed} % period) < {17'b0, half};
    endfunction

    // priority: trainer, tx pulse, display enable, confirmation, radio pattern
    function void advance_patterns(bit [31:0] ts);
      bit [31:0] elapsed;
      bit [63:0] total;
      if (trainer) return;
      if (tx_on) begin
        elapsed = ts - tx_t0;
        if (elapsed < {16'b0, tx_ms}) begin
          led = 1'b1;
          return;
        end
        tx_on = 1'b0;
      end
      if (!ble_en) begin
        led = 1'b0;
        return;
      end
      if (confirm_on) begin
        elapsed = ts - confirm_t0;
        total = 64'(confirm_cnt) * 64'(confirm_half) * 64'd2;
        if (64'(elapsed) < total) begin
          led = blink_lit(elapsed, confirm_half);
          return;
        end
        confirm_on = 1'b0;
        led = 1'b0;
      end
      if (radio == RadioPairing) led = blink_lit(ts - pattern_t0, pairing_half);
      else led = 1'b0;
    endfunction

    function void note_item(logic [2:0] op, logic [31:0] ts, logic [1:0] rs);
      case (op)
        OpTick: advance_patterns(ts);
        OpSetRadio: begin
          if (rs != RadioBadCode && rs != radio) begin
            if (rs == RadioConnected) begin
              confirm_on = 1'b1;
              confirm_t0 = ts;
            end
            radio = slpa_radio_e'(rs);
            pattern_t0 = ts;
          end
        end
        OpTxPulse: begin
          tx_on = 1'b1;
          tx_t0 = ts;
        end
        OpTrainerOn: begin
          trainer = 1'b1;
          led = 1'b1;
        end
        OpTrainerOff: begin
          led = 1'b0;
          trainer = 1'b0;
        end
        default: ;
      endcase
      pending_led.push_back(led);
    endfunction

    function void check_led(logic actual);
      bit want;
      if (pending_led.size() == 0) begin
        failures++;
        if (failures <= ReportMax)
          $display("%0t: led result %b with no item outstanding", $realtime, actual);
        return;
      end
      want = pending_led.pop_front();
      if (actual !== want) begin
        failures++;
        if (failures <= ReportMax)
          $display("%0t: led_on mismatch, expected %b got %b", $realtime, want, actual);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  slpa_in_if  in_ch();
  slpa_out_if out_ch();

  led_scoreboard sb;
  bit            src_idle_on;
  bit            snk_idle_on;
  bit            hold_req;
  int unsigned   cycles;
  logic [31:0]   clock_ms;

  status_led_pattern_arbiter_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("[status_led_pattern_arbiter_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (out_ch.valid && out_ch.ready) sb.check_led(out_ch.led_on);
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.operation, in_ch.now_ms, in_ch.new_radio_state);
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = LongHold;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (snk_idle_on && $urandom_range(99, 0) < 20) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [31:0] ts,
                           input logic [1:0] rs);
    while (src_idle_on && $urandom_range(99, 0) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= op;
    in_ch.now_ms          <= ts;
    in_ch.new_radio_state <= rs;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_led.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // narrow registers get junk in their upper bits, unused indexes get junk too
  task automatic set_config(input bit en, input int unsigned tx, input int unsigned ch,
                            input int unsigned cc, input int unsigned ph);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegBleEnable;
    cfg_wdata_i <= CfgDataW'(($urandom() << 1) | en);
    @(negedge clk_i);
    cfg_idx_i <= RegTxPulse;
    cfg_wdata_i <= CfgDataW'(tx);
    @(negedge clk_i);
    cfg_idx_i <= RegConfirmHalf;
    cfg_wdata_i <= CfgDataW'(ch);
    @(negedge clk_i);
    cfg_idx_i <= RegConfirmCnt;
    cfg_wdata_i <= CfgDataW'(($urandom() << CountW) | cc);
    @(negedge clk_i);
    cfg_idx_i <= RegPairingHalf;
    cfg_wdata_i <= CfgDataW'(ph);
    @(negedge clk_i);
    for (int i = RegPairingHalf + 1; i < 2 ** CfgIdxW; i++) begin
      cfg_idx_i <= CfgIdxW'(i);
      cfg_wdata_i <= CfgDataW'($urandom());
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input int n, input int unsigned max_step,
                           input int hold_at, input int pause_at);
    logic [2:0]  op;
    logic [1:0]  rs;
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if (k == pause_at) drain();
      pick = $urandom_range(99, 0);
      if (pick < 58) op = OpTick;
      else if (pick < 72) op = OpSetRadio;
      else if (pick < 82) op = OpTxPulse;
      else if (pick < 85) op = OpTrainerOn;
      else if (pick < 94) op = OpTrainerOff;
      else if (pick < 97) op = 3'($urandom_range(OpCodeMax, OpTrainerOff + 1));
      else op = 3'($urandom());
      if (op == OpSetRadio && $urandom_range(9, 0) != 0)
        rs = 2'($urandom_range(RadioPairing, RadioOff));
      else
        rs = 2'($urandom());
      pick = $urandom_range(99, 0);
      if (pick < 3) clock_ms = $urandom();
      else if (pick < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(max_step, 0);
      else clock_ms += $urandom_range(max_step, 0);
      send_item(op, clock_ms, rs);
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OpTick;
    in_ch.now_ms = '0;
    in_ch.new_radio_state = RadioOff;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    clock_ms = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values: display off, 50 ms pulse
    send_item(OpTick, 32'd0, RadioOff);
    send_item(OpTxPulse, 32'd10, RadioOff);
    send_item(OpTick, 32'd20, RadioOff);
    send_item(OpTick, 32'd60, RadioOff);
    drain();

    set_config(1'b1, 10, 5, 2, 7);
    for (int c = OpTrainerOff + 1; c <= OpCodeMax; c++) send_item(3'(c), 32'd90, RadioOff);
    send_item(OpSetRadio, 32'd95, RadioBadCode);
    send_item(OpSetRadio, 32'd100, RadioConnected);
    send_item(OpTick, 32'd103, RadioOff);
    send_item(OpTick, 32'd108, RadioOff);
    send_item(OpTick, 32'd112, RadioOff);
    send_item(OpTick, 32'd125, RadioOff);
    send_item(OpSetRadio, 32'd126, RadioConnected);
    send_item(OpSetRadio, 32'd130, RadioPairing);
    send_item(OpTick, 32'd131, RadioOff);
    send_item(OpTick, 32'd138, RadioOff);
    send_item(OpTrainerOn, 32'd139, RadioOff);
    send_item(OpTick, 32'd140, RadioOff);
    send_item(OpTrainerOff, 32'd141, RadioOff);
    send_item(OpTxPulse, 32'hFFFF_FFFA, RadioOff);
    send_item(OpTick, 32'h0000_0002, RadioOff);
    send_item(OpTick, 32'h0000_0010, RadioOff);
    send_item(OpSetRadio, 32'hFFFF_FFFF, RadioOff);
    send_item(OpTick, 32'hFFFF_FFFF, RadioOff);
    drain();

    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    set_config(1'b1, 6, 3, 2, 5);
    run_phase(190, 8, -1, -1);
    drain();

    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    set_config(1'b0, 20, 10, 3, 10);
    run_phase(190, 15, 20, -1);
    drain();

    set_config(1'b1, 65535, 65535, 255, 65535);
    run_phase(190, 30000, -1, 95);
    drain();

    set_config(1'b1, 0, 0, 0, 0);
    run_phase(190, 4, -1, -1);
    drain();

    set_config(1'b1, 1, 1, 1, 1);
    run_phase(190, 3, -1, -1);
    drain();

    set_config(1'b1, $urandom_range(40, 1), $urandom_range(20, 1),
               $urandom_range(8, 1), $urandom_range(30, 1));
    run_phase(190, 40, -1, -1);
    drain();

    set_config(1'($urandom()), $urandom_range(200, 1), $urandom_range(60, 1),
               $urandom_range(255, 1), $urandom_range(100, 1));
    run_phase(190, 60, -1, -1);
    drain();

    set_config(1'b1, TxPulseRst, ConfirmHalfRst, ConfirmCntRst, PairingHalfRst);
    run_phase(190, 300, -1, -1);
    drain();

    if (sb.failures == 0 && sb.pending_led.size() == 0)
      $display("[status_led_pattern_arbiter_unit] OK");
    else
      $display("[status_led_pattern_arbiter_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/slpa_pkg.sv
hw/rtl/slpa_if.sv
hw/rtl/status_led_pattern_arbiter_unit.sv
hw/rtl/slpa_checker.sv
verif/status_led_pattern_arbiter_unit_test.sv
